### src/mcfir_pkg.sv
// Package for the multichannel FIR filter: field widths, fixed-point constants,
// item codes and the command and status structs between controller and datapath.
// Depends on nothing; every other file of the block but mcfir_ram imports it.
package mcfir_pkg;

  // Field widths of the item and result channels.
  localparam int SAMPLE_W     = 24;
  localparam int COEF_W       = 18;
  localparam int CH_FIELD_W   = 3;
  localparam int CIDX_W       = 6;
  localparam int TAPS_FIELD_W = 7;

  // A Q1.23 sample times a Q2.16 coefficient.
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int FRAC_BITS = 16;

  localparam int ROUND_HALF = 32768;
  localparam int SAT_MAX    = 8388607;
  localparam int SAT_MIN    = -8388608;

  // Unity gain in Q2.16, the reset value of coefficient zero.
  localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sd65536;

  // Item codes carried in the cmd field.
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic clr_step;  // write one reset coefficient
    logic issue;     // issue the reads for one tap
    logic finish;    // round, saturate and load the output register
  } mcfir_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_sample;   // offered item is a sample for an existing channel
    logic clr_last;    // clearing sweep is at its final entry
    logic issue_last;  // current tap is the final one
    logic pipe_empty;  // no product left in flight
    logic out_free;    // output register can take a result
  } mcfir_sts_t;

endpackage

### src/mcfir_if.sv
// Valid/ready channel interfaces for the multichannel FIR filter: the item
// channel and the result channel. Depends on mcfir_pkg.
interface mcfir_in_if;
  import mcfir_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [CH_FIELD_W-1:0]        channel;
  logic signed [SAMPLE_W-1:0]   sample_in;
  logic [CIDX_W-1:0]            coef_index;
  logic signed [COEF_W-1:0]     coef_value;

  modport source (output valid, cmd, channel, sample_in, coef_index, coef_value,
                  input ready);
  modport sink (input valid, cmd, channel, sample_in, coef_index, coef_value,
                output ready);
endinterface

interface mcfir_out_if;
  import mcfir_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [CH_FIELD_W-1:0]        out_channel;
  logic signed [SAMPLE_W-1:0]   sample_out;
  logic                         clipped;

  modport source (output valid, out_channel, sample_out, clipped, input ready);
  modport sink (input valid, out_channel, sample_out, clipped, output ready);
endinterface

### src/multichannel_fir_filter.sv
// Top level of the multichannel direct-form FIR filter.
// Depends on mcfir_pkg, mcfir_if, mcfir_ctrl, mcfir_dp and mcfir_ram.
//
// Usage
// The item channel (in_ch) carries either a sample, with its channel number,
// or a coefficient load, with a tap index and a Q2.16 value. Each sample
// yields one result on out_ch: the channel, the Q1.23 sum over tap_count taps
// of coefficient times delayed sample of that channel, rounded half up and
// saturated, and a flag that is set when saturation took place. Loads, loads
// to a tap beyond MAX_TAPS and samples for a channel beyond NUM_CHANNELS give
// no result. A transfer on either channel happens when valid and ready are
// both high at a rising clock edge. tap_count is written through cfg_we and
// cfg_data and should only change while the filter is idle.
//
// Timing
// One multiply-accumulate unit is shared by all taps, so a sample's taps are
// worked through one after another, and no new item is taken until its result
// has been loaded into the output register. A load is taken while idle and leaves the block idle.
// After reset the coefficient memory is swept to its reset values (unity at
// tap zero, zero elsewhere), one entry per cycle, so in_ch.ready stays low until
// the sweep is done. Channel history is kept continuously across all samples.
// A finished result waits in the output register while the next item is
// taken; only if a second result is ready before the first has been
// transferred does the block hold off until out_ch.ready is seen.
module multichannel_fir_filter #(
  parameter int MAX_TAPS     = 64,
  parameter int NUM_CHANNELS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mcfir_pkg::TAPS_FIELD_W-1:0] cfg_data,
  mcfir_in_if.sink                           in_ch,
  mcfir_out_if.source                        out_ch
);
  import mcfir_pkg::*;

  mcfir_cmd_t cmd;
  mcfir_sts_t sts;

  // The controller only sequences; it sees the item channel's handshake and
  // the datapath's status, and the datapath does all of the arithmetic.
  mcfir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mcfir_dp #(
    .MAX_TAPS     (MAX_TAPS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_cmd        (in_ch.cmd),
    .in_channel    (in_ch.channel),
    .in_sample     (in_ch.sample_in),
    .in_coef_index (in_ch.coef_index),
    .in_coef_value (in_ch.coef_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_channel   (out_ch.out_channel),
    .out_sample    (out_ch.sample_out),
    .out_clipped   (out_ch.clipped)
  );

endmodule

### src/mcfir_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mcfir_ram #(
  parameter  int WIDTH = 24,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

### src/mcfir_ctrl.sv
// Sequencing state machine of the multichannel FIR filter.
// Depends on mcfir_pkg; drives the datapath through mcfir_cmd_t.
module mcfir_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mcfir_pkg::mcfir_sts_t sts,
  output mcfir_pkg::mcfir_cmd_t cmd
);
  import mcfir_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;
  logic   in_ready_nxt;

  assign in_ready = in_ready_r;

  // The ready register is high only in the idle state.
  assign cmd.accept   = in_ready_r && in_valid;
  assign cmd.clr_step = (state_r == S_CLEAR);
  assign cmd.issue    = (state_r == S_RUN);
  assign cmd.finish   = (state_r == S_FINISH) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && sts.is_sample) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
    in_ready_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

endmodule

### src/mcfir_dp.sv
// Datapath of the multichannel FIR filter: per-channel history pointers, the
// history and coefficient RAMs, the multiply-accumulate pipe and the output
// register. Depends on mcfir_pkg and mcfir_ram.
module mcfir_dp #(
  parameter int MAX_TAPS     = 64,
  parameter int NUM_CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mcfir_pkg::TAPS_FIELD_W-1:0]   cfg_data,
  input  logic                                 in_cmd,
  input  logic [mcfir_pkg::CH_FIELD_W-1:0]     in_channel,
  input  logic signed [mcfir_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [mcfir_pkg::CIDX_W-1:0]         in_coef_index,
  input  logic signed [mcfir_pkg::COEF_W-1:0]  in_coef_value,
  input  mcfir_pkg::mcfir_cmd_t                cmd,
  output mcfir_pkg::mcfir_sts_t                sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mcfir_pkg::CH_FIELD_W-1:0]     out_channel,
  output logic signed [mcfir_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                 out_clipped
);
  import mcfir_pkg::*;

  localparam int PTR_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SEEN_W = $clog2(MAX_TAPS + 1);
  localparam int TAPS_W = SEEN_W;
  localparam int CMP_W  = (TAPS_W > TAPS_FIELD_W) ? TAPS_W : TAPS_FIELD_W;
  localparam int ACC_W  = PROD_W + PTR_W + 1;
  localparam int HIST_DEPTH = 1 << (CH_W + PTR_W);

  // Configuration and per-channel bookkeeping.
  logic [TAPS_FIELD_W-1:0] tap_count_r;
  logic [SEEN_W-1:0]       seen_r  [NUM_CHANNELS];
  logic [PTR_W-1:0]        wp_r    [NUM_CHANNELS];
  sample_t                 first_r [NUM_CHANNELS];
  logic [PTR_W-1:0]        clr_idx_r;

  // Item being filtered.
  logic [CH_W-1:0]         ch_r;
  logic [CH_FIELD_W-1:0]   out_ch_lat_r;
  logic [SEEN_W-1:0]       seen_lat_r;
  sample_t                 first_lat_r;
  logic [PTR_W-1:0]        rd_pos_r;
  logic [PTR_W-1:0]        k_r;
  logic [PTR_W-1:0]        last_k_r;

  // Multiply-accumulate pipe.
  logic                    v1_r;
  logic                    v2_r;
  logic                    sel1_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  // Output register.
  logic                    out_valid_r;
  logic [CH_FIELD_W-1:0]   out_channel_r;
  sample_t                 out_sample_r;
  logic                    out_clipped_r;

  logic                    chan_ok;
  logic                    coef_ok;
  logic                    load_go;
  logic                    sample_go;
  logic [CH_W-1:0]         ch_idx;
  logic [SEEN_W-1:0]       seen_c;
  logic [PTR_W-1:0]        wp_c;
  logic [CMP_W-1:0]        tc_ext;
  logic [TAPS_W-1:0]       taps_eff;

  logic                    hist_we;
  logic [CH_W+PTR_W-1:0]   hist_waddr;
  logic [CH_W+PTR_W-1:0]   hist_raddr;
  logic [SAMPLE_W-1:0]     hist_rdata;
  logic                    coef_we;
  logic [PTR_W-1:0]        coef_waddr;
  logic [COEF_W-1:0]       coef_wdata;
  logic [COEF_W-1:0]       coef_rdata;

  sample_t                  sample_sel;
  coef_t                    coef_sel;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  q;
  logic signed [ACC_W-1:0]  sat_max_ext;
  logic signed [ACC_W-1:0]  sat_min_ext;
  sample_t                  res_sample;
  logic                     res_clip;

  assign chan_ok   = (int'(in_channel) < NUM_CHANNELS);
  assign coef_ok   = (int'(in_coef_index) < MAX_TAPS);
  assign load_go   = cmd.accept && (in_cmd == CMD_LOAD) && coef_ok;
  assign sample_go = cmd.accept && sts.is_sample;
  assign ch_idx    = CH_W'(in_channel);
  assign seen_c    = seen_r[ch_idx];
  assign wp_c      = wp_r[ch_idx];

  // Tap count zero acts as one, and anything above the maximum as the maximum.
  assign tc_ext = CMP_W'(tap_count_r);
  always_comb begin
    if (tap_count_r == '0) begin
      taps_eff = TAPS_W'(1);
    end else if (tc_ext > CMP_W'(MAX_TAPS)) begin
      taps_eff = TAPS_W'(MAX_TAPS);
    end else begin
      taps_eff = TAPS_W'(tap_count_r);
    end
  end

  assign sts.is_sample  = (in_cmd == CMD_FILTER) && chan_ok;
  assign sts.clr_last   = (clr_idx_r == PTR_W'(MAX_TAPS - 1));
  assign sts.issue_last = (k_r == last_k_r);
  assign sts.pipe_empty = !v1_r && !v2_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  // The new sample goes into history in the transfer cycle, ahead of any read.
  assign hist_we    = sample_go;
  assign hist_waddr = {ch_idx, wp_c};
  assign hist_raddr = {ch_r, rd_pos_r};

  assign coef_we    = cmd.clr_step || load_go;
  assign coef_waddr = cmd.clr_step ? clr_idx_r : PTR_W'(in_coef_index);
  always_comb begin
    if (cmd.clr_step) begin
      coef_wdata = (clr_idx_r == '0) ? COEF_ONE : '0;
    end else begin
      coef_wdata = in_coef_value;
    end
  end

  mcfir_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk     (clk),
    .we      (hist_we),
    .waddr   (hist_waddr),
    .wdata   (in_sample),
    .raddr   (hist_raddr),
    .rdata_r (hist_rdata)
  );

  mcfir_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk     (clk),
    .we      (coef_we),
    .waddr   (coef_waddr),
    .wdata   (coef_wdata),
    .raddr   (k_r),
    .rdata_r (coef_rdata)
  );

  // Past samples the channel has not yet received read as its first sample.
  assign sample_sel = sel1_r ? $signed(hist_rdata) : first_lat_r;
  assign coef_sel   = $signed(coef_rdata);
  assign prod_nxt   = sample_sel * coef_sel;

  // Round half up, floor by the arithmetic shift, then saturate.
  assign rnd         = acc_r + ACC_W'(ROUND_HALF);
  assign q           = rnd >>> FRAC_BITS;
  assign sat_max_ext = ACC_W'(SAT_MAX);
  assign sat_min_ext = ACC_W'(SAT_MIN);
  always_comb begin
    if (q > sat_max_ext) begin
      res_sample = SAMPLE_W'(SAT_MAX);
      res_clip   = 1'b1;
    end else if (q < sat_min_ext) begin
      res_sample = SAMPLE_W'(SAT_MIN);
      res_clip   = 1'b1;
    end else begin
      res_sample = q[SAMPLE_W-1:0];
      res_clip   = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAPS_FIELD_W'(1);
      clr_idx_r   <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        seen_r[i] <= '0;
        wp_r[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        tap_count_r <= cfg_data;
      end
      if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (sample_go) begin
        if (seen_c != SEEN_W'(MAX_TAPS)) begin
          seen_r[ch_idx] <= seen_c + 1'b1;
        end
        wp_r[ch_idx] <= (wp_c == PTR_W'(MAX_TAPS - 1)) ? '0 : wp_c + 1'b1;
      end
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (sample_go) begin
      if (seen_c == '0) begin
        first_r[ch_idx] <= in_sample;
        first_lat_r     <= in_sample;
      end else begin
        first_lat_r     <= first_r[ch_idx];
      end
      ch_r         <= ch_idx;
      out_ch_lat_r <= in_channel;
      seen_lat_r   <= seen_c;
      rd_pos_r     <= wp_c;
      k_r          <= '0;
      last_k_r     <= PTR_W'(taps_eff - 1'b1);
      acc_r        <= '0;
    end else begin
      if (cmd.issue) begin
        k_r      <= k_r + 1'b1;
        rd_pos_r <= (rd_pos_r == '0) ? PTR_W'(MAX_TAPS - 1) : rd_pos_r - 1'b1;
      end
      if (v2_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
    sel1_r <= (SEEN_W'(k_r) <= seen_lat_r);
    prod_r <= prod_nxt;
    if (cmd.finish) begin
      out_channel_r <= out_ch_lat_r;
      out_sample_r  <= res_sample;
      out_clipped_r <= res_clip;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_sample  = out_sample_r;
  assign out_clipped = out_clipped_r;

endmodule

### src/mcfir_chk.sv
// Port-level checker for the multichannel FIR filter, bound to the top level.
// Depends on mcfir_pkg and multichannel_fir_filter.
module mcfir_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_cmd,
  input logic out_valid,
  input logic out_ready
);
  import mcfir_pkg::*;

  // A result, once offered, stays until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn before transfer");

  // A coefficient load never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == CMD_LOAD) |=> !$rose(out_valid))
    else $error("result appeared after a coefficient load");

  // A new result is only loaded while the item channel is held off.
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result loaded while an item could be taken");

  // The coefficient sweep after reset keeps the item channel closed.
  a_reset_closed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("item channel open straight after reset");

endmodule

bind multichannel_fir_filter mcfir_chk u_mcfir_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_cmd    (in_ch.cmd),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

### bench/tb_multichannel_fir_filter.sv
// Self-checking bench for the multichannel FIR filter: random bursts of samples
// and coefficient loads, checked against a filter predictor held in the bench.
// Depends on mcfir_pkg, mcfir_if and the multichannel_fir_filter RTL.
`timescale 1ns / 1ps

module tb_multichannel_fir_filter;
  import mcfir_pkg::*;

  localparam int MAX_TAPS      = 64;
  localparam int NUM_CHANNELS  = 8;
  // Long enough for the longest sample to finish, with a comfortable margin.
  localparam int SETTLE_CYCLES = 80;
  // Cycles without any transfer on either channel before the run is abandoned.
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 36;

  // One item as offered on the input channel.
  typedef struct {
    logic                  cmd;
    logic [CH_FIELD_W-1:0] channel;
    sample_t               sample;
    logic [CIDX_W-1:0]     cidx;
    coef_t                 cval;
  } fir_item_t;

  // One filtered sample as it should appear on the result channel.
  typedef struct {
    logic [CH_FIELD_W-1:0] channel;
    sample_t               value;
    logic                  clipped;
  } fir_result_t;

  // Ways in which the result side holds off its ready.
  typedef enum logic [1:0] {
    SINK_FREE,
    SINK_COIN,
    SINK_LONG,
    SINK_RARE
  } sink_mode_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [TAPS_FIELD_W-1:0] cfg_data;

  mcfir_in_if  in_ch ();
  mcfir_out_if out_ch ();

  multichannel_fir_filter #(
    .MAX_TAPS     (MAX_TAPS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Items waiting to be offered, and filtered samples still owed by the block.
  fir_item_t   items_to_send [$];
  fir_result_t outputs_due [$];

  // The bench's own copy of the filter state.
  logic [TAPS_FIELD_W-1:0] tap_reg;
  coef_t                   coef_mem [MAX_TAPS];
  sample_t                 hist [NUM_CHANNELS][MAX_TAPS];
  sample_t                 first_smp [NUM_CHANNELS];
  int unsigned             seen_cnt [NUM_CHANNELS];
  int unsigned             wr_pos [NUM_CHANNELS];

  // Handshake flags, set at the rising edge and read by the falling-edge processes.
  bit in_xfer;
  bit out_xfer;

  int          mismatches;
  int          quiet_cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned mode_left;
  int unsigned hold_left;
  sink_mode_t  sink_mode;
  fir_item_t   next_item;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one accepted item to the predicted state. A sample pushes the
  // expected filter output; a load only updates the coefficient store.
  function automatic void absorb_item(fir_item_t it);
    int unsigned taps;
    int unsigned wp;
    int unsigned seen;
    longint      acc;
    longint      q;
    sample_t     s;
    fir_result_t r;
    if (it.cmd == CMD_LOAD) begin
      if (it.cidx < MAX_TAPS) coef_mem[it.cidx] = it.cval;
      return;
    end
    if (it.channel >= NUM_CHANNELS) return;

    // Out-of-range tap counts are clamped rather than rejected.
    taps = 32'(tap_reg);
    if (taps == 0) taps = 1;
    if (taps > MAX_TAPS) taps = MAX_TAPS;

    wp   = wr_pos[it.channel];
    seen = seen_cnt[it.channel];
    if (seen == 0) first_smp[it.channel] = it.sample;
    hist[it.channel][wp] = it.sample;

    // Taps that reach further back than the channel's history use its very
    // first sample in place of the missing past.
    acc = 0;
    for (int unsigned k = 0; k < taps; k++) begin
      if (k <= seen) s = hist[it.channel][(wp + MAX_TAPS - k) % MAX_TAPS];
      else s = first_smp[it.channel];
      acc += longint'(s) * longint'(coef_mem[k]);
    end

    if (seen < MAX_TAPS) seen_cnt[it.channel] = seen + 1;
    wr_pos[it.channel] = (wp + 1) % MAX_TAPS;

    // Round half up to Q1.23, then saturate.
    q = (acc + longint'(ROUND_HALF)) >>> FRAC_BITS;
    r.clipped = 1'b0;
    if (q > SAT_MAX) begin
      q = SAT_MAX;
      r.clipped = 1'b1;
    end else if (q < SAT_MIN) begin
      q = SAT_MIN;
      r.clipped = 1'b1;
    end
    r.channel = it.channel;
    r.value   = sample_t'(q);
    outputs_due.push_back(r);
  endfunction

  function automatic void compare_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Unused fields of each item carry random bits, so they are exercised too.
  task automatic queue_sample(input logic [CH_FIELD_W-1:0] ch, input sample_t x);
    fir_item_t it;
    it.cmd     = CMD_FILTER;
    it.channel = ch;
    it.sample  = x;
    it.cidx    = CIDX_W'($urandom);
    it.cval    = coef_t'($urandom);
    items_to_send.push_back(it);
  endtask

  task automatic queue_load(input logic [CIDX_W-1:0] idx, input coef_t v);
    fir_item_t it;
    it.cmd     = CMD_LOAD;
    it.channel = CH_FIELD_W'($urandom);
    it.sample  = sample_t'($urandom);
    it.cidx    = idx;
    it.cval    = v;
    items_to_send.push_back(it);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return sample_t'(SAT_MAX);
      1:       return sample_t'(SAT_MIN);
      2:       return sample_t'(int'($urandom_range(0, 511)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Small coefficients keep many sums in range; the extremes drive them to clip.
  function automatic coef_t pick_coef();
    case ($urandom_range(0, 9))
      0:       return coef_t'(131071);
      1:       return coef_t'(-131072);
      2:       return coef_t'(0);
      3:       return COEF_ONE;
      4, 5, 6: return coef_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return coef_t'($urandom);
    endcase
  endfunction

  // Channels 0 and 1 are favoured so that their history wraps round.
  task automatic queue_random(input int n);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_load(CIDX_W'($urandom_range(0, MAX_TAPS - 1)), pick_coef());
      end else if ($urandom_range(0, 1) != 0) begin
        queue_sample(CH_FIELD_W'($urandom_range(0, 1)), pick_sample());
      end else begin
        queue_sample(CH_FIELD_W'($urandom_range(0, NUM_CHANNELS - 1)), pick_sample());
      end
    end
  endtask

  // Wait until every queued item has been transferred and every owed result
  // has arrived, then let a load or a trailing sample finish inside the block.
  task automatic drain();
    do @(posedge clk);
    while (items_to_send.size() != 0 || in_ch.valid || outputs_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The tap count is only ever changed while the block is idle.
  task automatic set_taps(input logic [TAPS_FIELD_W-1:0] n);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= n;
    @(negedge clk);
    cfg_we   <= 1'b0;
    tap_reg = n;
  endtask

  // Sender: offers queued items in bursts of random length separated by
  // random gaps. An offered item is held until its transfer is seen.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_xfer) begin
      // Still waiting for the block to take the current item.
    end else if (gap_left != 0) begin
      gap_left--;
      in_ch.valid <= 1'b0;
    end else if (items_to_send.size() == 0) begin
      in_ch.valid <= 1'b0;
    end else begin
      next_item = items_to_send.pop_front();
      in_ch.valid      <= 1'b1;
      in_ch.cmd        <= next_item.cmd;
      in_ch.channel    <= next_item.channel;
      in_ch.sample_in  <= next_item.sample;
      in_ch.coef_index <= next_item.cidx;
      in_ch.coef_value <= next_item.cval;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 16);
        // A third of the bursts run straight into the next one.
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  end

  // Receiver: ready follows a mode that is drawn anew at random intervals,
  // from always ready through coin tosses to long stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (sink_mode)
        SINK_FREE: out_ch.ready <= 1'b1;
        SINK_COIN: out_ch.ready <= ($urandom_range(0, 1) != 0);
        SINK_LONG: begin
          if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) hold_left = $urandom_range(1, 40);
          end
        end
        default: out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Monitor: predicts on every input transfer, checks every result transfer
  // against the oldest expectation, and keeps the watchdog.
  always @(posedge clk) begin : monitor
    fir_item_t   got_item;
    fir_result_t want;
    in_xfer  = rst_n && in_ch.valid && in_ch.ready;
    out_xfer = rst_n && out_ch.valid && out_ch.ready;

    if (in_xfer) begin
      got_item.cmd     = in_ch.cmd;
      got_item.channel = in_ch.channel;
      got_item.sample  = in_ch.sample_in;
      got_item.cidx    = in_ch.coef_index;
      got_item.cval    = in_ch.coef_value;
      absorb_item(got_item);
    end

    if (out_xfer) begin
      if (outputs_due.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual ch %0d value %0d",
                 $time, out_ch.out_channel, out_ch.sample_out);
        mismatches++;
      end else begin
        want = outputs_due.pop_front();
        compare_field("out_channel", 32'(want.channel), 32'(out_ch.out_channel));
        compare_field("sample_out", 32'(want.value), 32'(out_ch.sample_out));
        compare_field("clipped", 32'(want.clipped), 32'(out_ch.clipped));
      end
    end

    if (in_xfer || out_xfer) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired after %0d cycles without a transfer",
               $time, QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [TAPS_FIELD_W-1:0] tap_plan [9];
    tap_plan = '{7'd0, 7'd127, 7'd65, 7'd2, 7'd5, 7'd17, 7'd33, 7'd64, 7'd1};

    // Every input is known from time zero onwards.
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_FILTER;
    in_ch.channel    = '0;
    in_ch.sample_in  = '0;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    out_ch.ready     = 1'b0;
    mismatches       = 0;
    quiet_cycles     = 0;
    burst_left       = 0;
    gap_left         = 0;
    mode_left        = 0;
    hold_left        = 0;
    sink_mode        = SINK_FREE;

    // Predictor state after reset: one tap, unity gain at tap zero.
    tap_reg = 1;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    coef_mem[0] = COEF_ONE;
    foreach (seen_cnt[c]) begin
      seen_cnt[c]  = 0;
      wr_pos[c]    = 0;
      first_smp[c] = '0;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset tap count of one with unity gain: the sample passes straight
    // through, including both extremes, zero and minus one.
    queue_sample(0, sample_t'(SAT_MAX));
    queue_sample(0, sample_t'(SAT_MIN));
    queue_sample(0, sample_t'(0));
    queue_sample(7, sample_t'(-1));
    // Gain close to two saturates at the top and bottom.
    queue_load(0, coef_t'(131071));
    queue_sample(0, sample_t'(SAT_MAX));
    queue_sample(0, sample_t'(SAT_MIN));
    // Most negative gain flips the extremes and clips both ways.
    queue_load(0, coef_t'(-131072));
    queue_sample(0, sample_t'(SAT_MIN));
    queue_sample(7, sample_t'(SAT_MAX));
    // Half gain puts both signs exactly on a rounding boundary.
    queue_load(0, coef_t'(32768));
    queue_sample(3, sample_t'(1));
    queue_sample(3, sample_t'(-1));
    queue_load(63, coef_t'(-1));
    drain();

    // Full length filter on channels that have not yet seen a sample, so
    // that the missing past is filled from each channel's first sample.
    set_taps(7'd64);
    queue_load(0, COEF_ONE);
    queue_load(1, coef_t'(32768));
    queue_load(5, coef_t'(-65536));
    queue_load(63, coef_t'(131071));
    queue_sample(1, sample_t'(1000));
    queue_sample(1, sample_t'(-2000));
    queue_sample(1, sample_t'(3000));
    queue_sample(2, sample_t'(SAT_MAX));
    queue_sample(4, sample_t'(SAT_MIN));
    queue_sample(4, sample_t'(SAT_MIN));
    drain();

    // Random phases over a spread of tap counts, including zero and values
    // beyond the maximum, which the block clamps.
    foreach (tap_plan[p]) begin
      set_taps(tap_plan[p]);
      queue_random(PHASE_ITEMS);
      drain();
    end
    set_taps(TAPS_FIELD_W'($urandom_range(3, MAX_TAPS - 1)));
    queue_random(PHASE_ITEMS);
    drain();

    if (mismatches == 0 && outputs_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
